// File: src/plist_pkg.sv
// Shared types, codes and defaults for the positional list unit.
package plist_pkg;

  // Default sizes
  localparam int CAPACITY_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int ACTION_W = 2;
  localparam int POS_W    = 5;
  localparam int ITEM_W   = 16;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 5;
  localparam int TOTAL_W  = 5;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 16;

  // Matches examined per cycle during a find
  localparam int SCAN_GROUP = 8;

  // Request codes
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ERASE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  // Found index when nothing was found
  localparam logic [INDEX_W-1:0] INDEX_NONE = 5'h1F;

  // Per-cycle command to every cell
  typedef struct packed {
    logic shift_up;    // insert: open a slot at the position
    logic shift_down;  // erase: close the slot at the position
    logic find;        // capture the compare result
  } cell_ctrl_t;

  // Scan unit status
  typedef struct packed {
    logic done;
    logic hit;
  } scan_res_t;

endpackage

// File: src/plist_cell.sv
// One list cell: holds an entry, shifts with its neighbors, compares on find.
module plist_cell import plist_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int CMP_W       = POS_W,
  parameter int IDX         = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cell_ctrl_t             ctrl,
  input  logic [CMP_W-1:0]       pos,
  input  logic [CMP_W-1:0]       count,
  input  logic [VALUE_WIDTH-1:0] item,
  input  logic [VALUE_WIDTH-1:0] left_value,
  input  logic [VALUE_WIDTH-1:0] right_value,
  output logic [VALUE_WIDTH-1:0] value,
  output logic                   match
);

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

  logic [VALUE_WIDTH-1:0] value_next;
  logic                   match_next;

  // Pick the next entry from the left neighbor, the new item or the right neighbor
  always_comb begin
    value_next = value;
    if (ctrl.shift_up) begin
      if (MY_IDX > pos) begin
        value_next = left_value;
      end else if (MY_IDX == pos) begin
        value_next = item;
      end
    end else if (ctrl.shift_down) begin
      if (MY_IDX >= pos) begin
        value_next = right_value;
      end
    end
  end

  // Compare only entries that are in use
  assign match_next = (value == item) && (MY_IDX < count);

  // Hold the entry and the compare result
  always_ff @(posedge clk) begin
    value <= value_next;
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.find) begin
      match <= match_next;
    end
  end

endmodule

// File: src/plist_scan.sv
// Find scan: walks the captured match flags a group per cycle, lowest index first.
module plist_scan import plist_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [CAPACITY-1:0] match_in,
  output scan_res_t           res,
  output logic [CNT_W-1:0]    index
);

  localparam int GRP = (CAPACITY < SCAN_GROUP) ? CAPACITY : SCAN_GROUP;
  localparam int GW  = $clog2(GRP);

  logic [CAPACITY-1:0] vec;
  logic [CAPACITY-1:0] cur;
  logic [CAPACITY-1:0] rest;
  logic [CNT_W-1:0]    base;
  logic [CNT_W-1:0]    cur_base;
  logic [GW-1:0]       enc;
  logic                hit;
  logic                busy;

  // Current group and what is left after it
  always_comb begin
    cur      = start ? match_in : vec;
    cur_base = start ? '0 : base;
    rest     = cur >> GRP;
    hit      = |cur[GRP-1:0];
    enc      = '0;
    for (int k = GRP - 1; k >= 0; k--) begin
      if (cur[k]) begin
        enc = GW'(k);
      end
    end
  end

  assign res.done = (start || busy) && (hit || (rest == '0));
  assign res.hit  = hit;
  assign index    = cur_base + CNT_W'(enc);

  // Advance one group per cycle until a hit or nothing is left
  always_ff @(posedge clk) begin
    vec  <= rest;
    base <= cur_base + CNT_W'(GRP);
    if (rst) begin
      busy <= 1'b0;
    end else if (res.done) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end
  end

endmodule

// File: src/positional_list_insert_erase_find_unit.sv
// Positional list unit top level: cell row, find scan, control and result register.
//
// Ordered list of up to CAPACITY values with insert, erase and find requests, one result
// per request. On a successful insert or erase the cells from the position up shift with
// their neighbors at the accepting edge and the result is registered there. Find compares
// in all cells at the accepting edge, then the scan unit examines 8 captured matches per
// cycle, lowest index first; the result is registered at the first match or when none is left.
// One request is in work at a time; a new request is accepted once the unit is idle and
// the result register is empty or being read in that cycle. Entries at or above the
// count are never returned.
module positional_list_insert_erase_find_unit import plist_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // [1:0] action, [6:2] position, [22:7] item_value, [23] zero
  input  logic [S_DATA_W-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // [2:0] status, [7:3] found_index, [12:8] entry_total, [13] is_empty, [15:14] zero
  output logic [M_DATA_W-1:0] m_tdata
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int ITEM_K = (VALUE_WIDTH < ITEM_W) ? VALUE_WIDTH : ITEM_W;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

  typedef enum logic {IDLE, SCAN} state_t;

  state_t                 state;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [ACTION_W-1:0]    action;
  logic [POS_W-1:0]       position;
  logic [VALUE_WIDTH-1:0] item;
  logic [CMP_W-1:0]       pos_ext;
  logic [CMP_W-1:0]       count_ext;
  logic                   in_xfer;
  logic                   out_free;
  logic                   out_load;
  logic                   find_start;
  cell_ctrl_t             ctrl;
  logic [STATUS_W-1:0]    req_status;
  logic                   scan_start;
  scan_res_t              scan_res;
  logic [CNT_W-1:0]       scan_index;
  logic [CAPACITY-1:0]    match_vec;
  logic [VALUE_WIDTH-1:0] cell_val [CAPACITY];

  logic [STATUS_W-1:0]    out_status;
  logic [INDEX_W-1:0]     out_index;
  logic [TOTAL_W-1:0]     out_total;
  logic                   out_empty;

  // Unpack the request
  assign action    = s_tdata[1:0];
  assign position  = s_tdata[6:2];
  assign item      = VALUE_WIDTH'(s_tdata[7 +: ITEM_K]);
  assign pos_ext   = CMP_W'(position);
  assign count_ext = CMP_W'(count);

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == IDLE) && out_free;
  assign in_xfer  = s_tvalid && s_tready;

  // Start a scan on a find, load the result register when a request finishes
  assign find_start = in_xfer && (action == ACT_FIND);
  assign out_load   = (in_xfer && (action != ACT_FIND)) || ((state == SCAN) && scan_res.done);

  // Decode the request and check it against the count
  always_comb begin
    ctrl       = '0;
    count_next = count;
    req_status = ST_BADPOS;
    unique case (action)
      ACT_INSERT: begin
        if (count == FULL_COUNT) begin
          req_status = ST_FULL;
        end else if (pos_ext > count_ext) begin
          req_status = ST_BADPOS;
        end else begin
          req_status    = ST_DONE;
          ctrl.shift_up = in_xfer;
          count_next    = count + 1'b1;
        end
      end
      ACT_ERASE: begin
        if (count == '0) begin
          req_status = ST_EMPTY;
        end else if (pos_ext >= count_ext) begin
          req_status = ST_BADPOS;
        end else begin
          req_status      = ST_DONE;
          ctrl.shift_down = in_xfer;
          count_next      = count - 1'b1;
        end
      end
      ACT_FIND: begin
        req_status = ST_NOTFOUND;
        ctrl.find  = in_xfer;
      end
      default: begin
        req_status = ST_BADPOS;
      end
    endcase
  end

  // Row of cells, each wired to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_v;
    logic [VALUE_WIDTH-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = cell_val[i];
    end else begin : g_left
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[i];
    end else begin : g_right
      assign right_v = cell_val[i+1];
    end
    plist_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .CMP_W       (CMP_W),
      .IDX         (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .pos         (pos_ext),
      .count       (count_ext),
      .item        (item),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (cell_val[i]),
      .match       (match_vec[i])
    );
  end

  plist_scan #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (scan_start),
    .match_in (match_vec),
    .res      (scan_res),
    .index    (scan_index)
  );

  // Hold state, count and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      count      <= '0;
      scan_start <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      scan_start <= find_start;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_xfer) begin
            count <= count_next;
            if (action == ACT_FIND) begin
              state      <= SCAN;
            end else begin
              out_status <= req_status;
              out_index  <= INDEX_NONE;
              out_total  <= TOTAL_W'(count_next);
              out_empty  <= (count_next == '0);
            end
          end
        end
        SCAN: begin
          if (scan_res.done) begin
            state      <= IDLE;
            out_status <= scan_res.hit ? ST_DONE : ST_NOTFOUND;
            out_index  <= scan_res.hit ? INDEX_W'(scan_index) : INDEX_NONE;
            out_total  <= TOTAL_W'(count);
            out_empty  <= (count == '0);
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {2'b00, out_empty, out_total, out_index, out_status};

endmodule

// File: src/plist_checker.sv
// Port-level checks for the positional list unit, bound to the top level.
module plist_checker import plist_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  found_index;
  logic [TOTAL_W-1:0]  entry_total;
  logic                is_empty;

  assign status      = m_tdata[2:0];
  assign found_index = m_tdata[7:3];
  assign entry_total = m_tdata[12:8];
  assign is_empty    = m_tdata[13];

  // Empty flag agrees with the reported count
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (is_empty == (entry_total == '0)))
    else $error("is_empty disagrees with entry_total");

  // A failed find reports no index
  a_notfound_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (status == ST_NOTFOUND)) |-> (found_index == INDEX_NONE))
    else $error("not-found result carries an index");

  // A full refusal reports a full list
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (status == ST_FULL)) |-> (entry_total == TOTAL_W'(CAPACITY)))
    else $error("full status with a count below capacity");

  // An empty refusal reports an empty list
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (status == ST_EMPTY)) |-> is_empty)
    else $error("empty status with entries present");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

endmodule

bind positional_list_insert_erase_find_unit plist_checker #(
  .CAPACITY (CAPACITY)
) u_plist_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
